@@ hw/rtl/nru_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// nru_pkg
// Shared types, constants and codes of the nucleation rate unit.
// -----------------------------------------------------------------------------
package nru_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned SatLimitFactor = 1000;

  localparam logic [31:0] SatLowReset = 32'(64'd1 << FracBits);
  localparam logic [63:0] SatHighWide = 64'(SatLimitFactor) << FracBits;
  localparam logic [31:0] SatHighReset =
    (SatHighWide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : SatHighWide[31:0];

  localparam logic [63:0] Ln2Q64   = 64'hB172_17F7_D1CF_79AB;
  localparam logic [63:0] Log2eQ63 = 64'hB8AA_3B29_5C17_F0BB;
  localparam logic [63:0] OneQ63   = 64'h8000_0000_0000_0000;
  localparam logic [47:0] LnSqMax  = 48'hFFFF_FFFF_FFFF;
  localparam logic [37:0] QuotMax  = 38'h3F_FFFF_FFFF;

  localparam int unsigned SqSteps   = 32;
  localparam int unsigned DivStages = 48;  // two quotient bits per stage
  localparam int unsigned SerTerms  = 24;
  localparam int unsigned DivShift  = 64 - FracBits;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgRegs  = 6;

  typedef enum logic [2:0] {
    CfgSatLow      = 3'd0,
    CfgSatHigh     = 3'd1,
    CfgCoefLow     = 3'd2,
    CfgCoefHigh    = 3'd3,
    CfgBarrierLow  = 3'd4,
    CfgBarrierHigh = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RegNone = 2'd0,
    RegLow  = 2'd1,
    RegHigh = 2'd2
  } regime_e;

  typedef struct packed {
    logic [31:0] sat_low;
    logic [31:0] sat_high;
    logic [31:0] coef_low;
    logic [31:0] coef_high;
    logic [31:0] barrier_low;
    logic [31:0] barrier_high;
  } nru_cfg_t;

  // One item in flight; each stage touches only the fields it needs.
  typedef struct packed {
    logic               kill;
    regime_e            regime;
    logic [31:0]        coef;
    logic [31:0]        barrier;
    logic               szero;
    logic signed [6:0]  expo;
    logic [63:0]        m;
    logic [31:0]        frac;
    logic [38:0]        mag;
    logic [75:0]        pp0;
    logic [75:0]        pp1;
    logic [75:0]        pp2;
    logic [75:0]        pp3;
    logic [47:0]        l2;
    logic [47:0]        rem;
    logic [38:0]        quo;
    logic               qsat;
    logic               uflow;
    logic [5:0]         nsh;
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        sum;
    logic [63:0]        v;
    logic [63:0]        rate;
  } nru_item_t;

endpackage
`default_nettype wire

@@ hw/rtl/nru_if.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// nru_in_if / nru_out_if
// Valid/ready channels for input items and result items.
// -----------------------------------------------------------------------------
interface nru_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] saturation;
  logic [5:0]  moment_order;

  modport source (output valid, saturation, moment_order, input ready);
  modport sink   (input valid, saturation, moment_order, output ready);
endinterface

interface nru_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] rate;
  logic [1:0]  regime;

  modport source (output valid, rate, regime, input ready);
  modport sink   (input valid, rate, regime, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/nru_regs.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// nru_regs
// APB register file holding limits, prefactors and barrier coefficients.
// -----------------------------------------------------------------------------
module nru_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [nru_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output      logic [31:0]                   prdata,
  output      logic                          pready,
  output      nru_pkg::nru_cfg_t             cfg_o
);
  import nru_pkg::*;

  nru_cfg_t cfg_q;
  cfg_idx_e idx;
  logic     wr;

  assign idx    = cfg_idx_e'(paddr[CfgAddrW-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sat_low      <= SatLowReset;
      cfg_q.sat_high     <= SatHighReset;
      cfg_q.coef_low     <= '0;
      cfg_q.coef_high    <= '0;
      cfg_q.barrier_low  <= '0;
      cfg_q.barrier_high <= '0;
    end else if (wr) begin
      unique case (idx)
        CfgSatLow:      cfg_q.sat_low      <= pwdata;
        CfgSatHigh:     cfg_q.sat_high     <= pwdata;
        CfgCoefLow:     cfg_q.coef_low     <= pwdata;
        CfgCoefHigh:    cfg_q.coef_high    <= pwdata;
        CfgBarrierLow:  cfg_q.barrier_low  <= pwdata;
        CfgBarrierHigh: cfg_q.barrier_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      CfgSatLow:      prdata = cfg_q.sat_low;
      CfgSatHigh:     prdata = cfg_q.sat_high;
      CfgCoefLow:     prdata = cfg_q.coef_low;
      CfgCoefHigh:    prdata = cfg_q.coef_high;
      CfgBarrierLow:  prdata = cfg_q.barrier_low;
      CfgBarrierHigh: prdata = cfg_q.barrier_high;
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/nucleation_rate_unit_core.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// nucleation_rate_unit_core
// Classical nucleation rate J = B * exp(-A / ln(S)^2), fully pipelined.
// -----------------------------------------------------------------------------
// Takes one transaction per clock unless stalled and returns one result per
// transaction, in order. The pipe is a decode stage, 32 squaring steps of log2
// (two stages each, partial products then sum), five stages forming ln(S)^2,
// 48 division stages at two quotient bits each, four stages forming the exp
// argument, 24 series terms at five stages each (product, sum, reciprocal
// product, sum, correction) and three stages for the prefactor product. The
// whole pipe advances together; it holds only while a finished result sits at
// the output unaccepted, and then input ready drops in the same cycle.
// Configuration is sampled at decode, so write registers only while idle.
// -----------------------------------------------------------------------------
module nucleation_rate_unit_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  nru_in_if.sink                             item_i,
  nru_out_if.source                          result_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [nru_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output      logic [31:0]                   prdata,
  output      logic                          pready
);
  import nru_pkg::*;

  // stage map
  localparam int unsigned StSq   = 1;
  localparam int unsigned StAbs  = StSq + 2 * SqSteps;
  localparam int unsigned StLnP  = StAbs + 1;
  localparam int unsigned StLnS  = StAbs + 2;
  localparam int unsigned StSqr  = StAbs + 3;
  localparam int unsigned StL2   = StAbs + 4;
  localparam int unsigned StDiv  = StL2 + 1;
  localparam int unsigned StTP   = StDiv + DivStages;
  localparam int unsigned StTS   = StTP + 1;
  localparam int unsigned StXP   = StTP + 2;
  localparam int unsigned StXS   = StTP + 3;
  localparam int unsigned StSer  = StXS + 1;
  localparam int unsigned StShr  = StSer + 5 * SerTerms;
  localparam int unsigned StJP   = StShr + 1;
  localparam int unsigned StJS   = StShr + 2;
  localparam int unsigned NStages = StJS + 1;

  nru_cfg_t  cfg;
  nru_item_t stg_q [NStages];
  nru_item_t nxt   [NStages];
  logic [NStages-1:0] vld_q;
  logic      en;

  nru_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  // ---------------------------------------------------------------- functions
  function automatic nru_item_t f_decode(logic [31:0] s, logic [5:0] order,
                                         nru_cfg_t c);
    nru_item_t it;
    logic      lo_sel;
    logic      hi_sel;
    logic [4:0] p;
    it     = '0;
    lo_sel = (s > c.sat_low) && (s < c.sat_high);
    hi_sel = (s >= c.sat_high);
    p      = '0;
    for (int i = 1; i < 32; i++) begin
      if (s[i]) p = 5'(i);
    end
    it.kill    = (order != '0) || !(lo_sel || hi_sel);
    it.regime  = lo_sel ? RegLow : RegHigh;
    it.coef    = lo_sel ? c.coef_low : c.coef_high;
    it.barrier = lo_sel ? c.barrier_low : c.barrier_high;
    it.szero   = (s == '0);
    it.expo    = $signed({2'b00, p}) - $signed(7'(FracBits));
    it.m       = {32'b0, s} << (6'd62 - {1'b0, p});
    return it;
  endfunction

  function automatic nru_item_t f_sq_mul(nru_item_t it);
    nru_item_t o;
    o     = it;
    o.pp0 = 76'(it.m[31:0])  * 76'(it.m[31:0]);
    o.pp1 = 76'(it.m[31:0])  * 76'(it.m[63:32]);
    o.pp2 = 76'(it.m[63:32]) * 76'(it.m[63:32]);
    return o;
  endfunction

  function automatic nru_item_t f_sq_sum(nru_item_t it);
    nru_item_t    o;
    logic [127:0] prod;
    logic [63:0]  nm;
    o    = it;
    prod = {it.pp2[63:0], 64'b0} + {31'b0, it.pp1[63:0], 33'b0}
         + {64'b0, it.pp0[63:0]};
    nm     = prod[125:62];
    o.frac = {it.frac[30:0], nm[63]};
    o.m    = nm[63] ? (nm >> 1) : nm;
    return o;
  endfunction

  function automatic nru_item_t f_abs(nru_item_t it);
    nru_item_t         o;
    logic signed [38:0] v;
    o     = it;
    v     = {it.expo, it.frac};
    o.mag = v[38] ? 39'(-v) : 39'(v);
    return o;
  endfunction

  function automatic nru_item_t f_ln_mul(nru_item_t it);
    nru_item_t o;
    o     = it;
    o.pp0 = 76'(it.mag[37:0]) * 76'(Ln2Q64[31:0]);
    o.pp1 = 76'(it.mag[37:0]) * 76'(Ln2Q64[63:32]);
    return o;
  endfunction

  function automatic nru_item_t f_ln_sum(nru_item_t it);
    nru_item_t    o;
    logic [102:0] sum;
    o     = it;
    sum   = 103'(it.pp0[69:0]) + {1'b0, it.pp1[69:0], 32'b0};
    o.mag = sum[102:64];
    return o;
  endfunction

  function automatic nru_item_t f_ln_sqr(nru_item_t it);
    nru_item_t o;
    o     = it;
    o.pp0 = 76'(it.mag[36:0]) * 76'(it.mag[36:0]);
    return o;
  endfunction

  function automatic nru_item_t f_l2(nru_item_t it);
    nru_item_t o;
    o      = it;
    o.l2   = it.szero ? LnSqMax : {4'b0, it.pp0[75:32]};
    o.kill = it.kill || (o.l2 == '0);
    o.rem  = '0;
    o.quo  = '0;
    o.qsat = 1'b0;
    return o;
  endfunction

  // one restoring step of (A << DivShift) / l2, bit position i of the dividend
  function automatic nru_item_t f_div1(nru_item_t it, int i);
    nru_item_t   o;
    logic        bin;
    logic [48:0] r;
    logic        qb;
    logic [39:0] qf;
    o   = it;
    bin = 1'b0;
    if (i >= int'(DivShift) && i - int'(DivShift) < 32) begin
      bin = it.barrier[5'(i - int'(DivShift))];
    end
    r  = {it.rem, bin};
    qb = (r >= {1'b0, it.l2});
    if (qb) r = r - {1'b0, it.l2};
    qf     = {it.quo, qb};
    o.rem  = r[47:0];
    o.qsat = it.qsat | qf[39] | qf[38];
    o.quo  = qf[38:0];
    return o;
  endfunction

  function automatic nru_item_t f_t_mul(nru_item_t it);
    nru_item_t   o;
    logic [37:0] qv;
    o     = it;
    qv    = it.qsat ? QuotMax : it.quo[37:0];
    o.pp0 = 76'(qv) * 76'(Log2eQ63[31:0]);
    o.pp1 = 76'(qv) * 76'(Log2eQ63[63:32]);
    return o;
  endfunction

  function automatic nru_item_t f_t_sum(nru_item_t it);
    nru_item_t    o;
    logic [102:0] sum;
    logic [38:0]  t;
    o       = it;
    sum     = 103'(it.pp0[69:0]) + {1'b0, it.pp1[69:0], 32'b0};
    t       = sum[101:63];
    o.uflow = t[38];
    o.nsh   = t[37:32];
    o.frac  = t[31:0];
    return o;
  endfunction

  function automatic nru_item_t f_x_mul(nru_item_t it);
    nru_item_t o;
    o     = it;
    o.pp0 = 76'(it.frac) * 76'(Ln2Q64[31:0]);
    o.pp1 = 76'(it.frac) * 76'(Ln2Q64[63:32]);
    return o;
  endfunction

  function automatic nru_item_t f_x_sum(nru_item_t it);
    nru_item_t   o;
    logic [95:0] prod;
    o      = it;
    prod   = 96'(it.pp0[63:0]) + {it.pp1[63:0], 32'b0};
    o.x    = {1'b0, prod[95:33]};
    o.term = OneQ63;
    o.sum  = OneQ63;
    return o;
  endfunction

  function automatic nru_item_t f_mul4(nru_item_t it, logic [63:0] a,
                                      logic [63:0] b);
    nru_item_t o;
    o     = it;
    o.pp0 = 76'(a[31:0])  * 76'(b[31:0]);
    o.pp1 = 76'(a[31:0])  * 76'(b[63:32]);
    o.pp2 = 76'(a[63:32]) * 76'(b[31:0]);
    o.pp3 = 76'(a[63:32]) * 76'(b[63:32]);
    return o;
  endfunction

  function automatic logic [127:0] f_sum4(nru_item_t it);
    return {it.pp3[63:0], 64'b0} + {32'b0, it.pp1[63:0], 32'b0}
         + {32'b0, it.pp2[63:0], 32'b0} + {64'b0, it.pp0[63:0]};
  endfunction

  function automatic nru_item_t f_ser_v(nru_item_t it);
    nru_item_t    o;
    logic [127:0] prod;
    o    = it;
    prod = f_sum4(it);
    o.v  = prod[126:63];
    return o;
  endfunction

  function automatic nru_item_t f_ser_qe(nru_item_t it);
    nru_item_t    o;
    logic [127:0] prod;
    o      = it;
    prod   = f_sum4(it);
    o.term = prod[127:64];
    return o;
  endfunction

  // reciprocal estimate is low by at most one; fix it, then fold into the sum
  function automatic nru_item_t f_ser_fix(nru_item_t it, logic [4:0] k, logic odd);
    nru_item_t   o;
    logic [63:0] r;
    logic [63:0] q;
    o = it;
    r = it.v - 64'(it.term * 64'(k));
    q = (r >= 64'(k)) ? it.term + 64'd1 : it.term;
    o.term = q;
    if (odd) o.sum = (q > it.sum) ? 64'd0 : it.sum - q;
    else     o.sum = it.sum + q;
    return o;
  endfunction

  function automatic nru_item_t f_shr(nru_item_t it);
    nru_item_t o;
    o     = it;
    o.sum = it.uflow ? 64'd0 : (it.sum >> it.nsh);
    return o;
  endfunction

  function automatic nru_item_t f_j_mul(nru_item_t it);
    nru_item_t o;
    o     = it;
    o.pp0 = 76'(it.coef) * 76'(it.sum[31:0]);
    o.pp1 = 76'(it.coef) * 76'(it.sum[63:32]);
    return o;
  endfunction

  function automatic nru_item_t f_j_sum(nru_item_t it);
    nru_item_t   o;
    logic [95:0] prod;
    o      = it;
    prod   = 96'(it.pp0[63:0]) + {it.pp1[63:0], 32'b0};
    o.rate = it.kill ? 64'd0 : prod[94:31];
    o.regime = it.kill ? RegNone : it.regime;
    return o;
  endfunction

  // ---------------------------------------------------------------- datapath
  assign nxt[0] = f_decode(item_i.saturation, item_i.moment_order, cfg);

  for (genvar g = 0; g < SqSteps; g++) begin : g_sq
    assign nxt[StSq + 2*g]     = f_sq_mul(stg_q[StSq + 2*g - 1]);
    assign nxt[StSq + 2*g + 1] = f_sq_sum(stg_q[StSq + 2*g]);
  end

  assign nxt[StAbs] = f_abs(stg_q[StAbs - 1]);
  assign nxt[StLnP] = f_ln_mul(stg_q[StLnP - 1]);
  assign nxt[StLnS] = f_ln_sum(stg_q[StLnS - 1]);
  assign nxt[StSqr] = f_ln_sqr(stg_q[StSqr - 1]);
  assign nxt[StL2]  = f_l2(stg_q[StL2 - 1]);

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    assign nxt[StDiv + g] =
      f_div1(f_div1(stg_q[StDiv + g - 1], 95 - 2*g), 94 - 2*g);
  end

  assign nxt[StTP] = f_t_mul(stg_q[StTP - 1]);
  assign nxt[StTS] = f_t_sum(stg_q[StTS - 1]);
  assign nxt[StXP] = f_x_mul(stg_q[StXP - 1]);
  assign nxt[StXS] = f_x_sum(stg_q[StXS - 1]);

  // series for exp(-f*ln2): term_k = (term_{k-1} * x) / k
  for (genvar g = 0; g < SerTerms; g++) begin : g_ser
    localparam int unsigned Base = StSer + 5*g;
    localparam logic [4:0]  K    = 5'(g + 1);
    localparam logic [63:0] Rcp  = 64'hFFFF_FFFF_FFFF_FFFF / (g + 1);
    assign nxt[Base]     = f_mul4(stg_q[Base - 1], stg_q[Base - 1].term,
                                  stg_q[Base - 1].x);
    assign nxt[Base + 1] = f_ser_v(stg_q[Base]);
    assign nxt[Base + 2] = f_mul4(stg_q[Base + 1], stg_q[Base + 1].v, Rcp);
    assign nxt[Base + 3] = f_ser_qe(stg_q[Base + 2]);
    assign nxt[Base + 4] = f_ser_fix(stg_q[Base + 3], K, K[0]);
  end

  assign nxt[StShr] = f_shr(stg_q[StShr - 1]);
  assign nxt[StJP]  = f_j_mul(stg_q[StJP - 1]);
  assign nxt[StJS]  = f_j_sum(stg_q[StJS - 1]);

  // ---------------------------------------------------------------- control
  // pipe moves as a whole unless the output holds an unaccepted result
  assign en           = !vld_q[NStages-1] || result_o.ready;
  assign item_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStages-2:0], item_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < int'(NStages); k++) begin
        stg_q[k] <= nxt[k];
      end
    end
  end

  assign result_o.valid  = vld_q[NStages-1];
  assign result_o.rate   = stg_q[NStages-1].rate;
  assign result_o.regime = stg_q[NStages-1].regime;

endmodule
`default_nettype wire

@@ hw/rtl/nru_checker.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// nru_checker
// Port-level assertions for the nucleation rate unit, bound to the top level.
// -----------------------------------------------------------------------------
module nru_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [63:0] rate_i,
  input wire logic [1:0]  regime_i,
  input wire logic        pready_i
);
  import nru_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(rate_i) && $stable(regime_i))
    else $error("result changed while stalled");

  // a zero regime always carries a zero rate
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (regime_i == RegNone) |-> rate_i == 64'd0)
    else $error("nonzero rate with no regime");

  // input only blocks while a result waits at the output
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input blocked without output stall");

  // an unused regime code never appears
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> regime_i != 2'd3)
    else $error("illegal regime code");

  // register port never wait-states
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i || !in_valid_i |-> pready_i)
    else $error("pready low");

endmodule

bind nucleation_rate_unit_core nru_checker u_nru_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .rate_i      (result_o.rate),
  .regime_i    (result_o.regime),
  .pready_i    (pready)
);
`default_nettype wire
